// ===== hw/rtl/siso_state_space_evaluator_core_defines.svh =====
// Assertion macros shared by the evaluator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SISO_STATE_SPACE_EVALUATOR_CORE_DEFINES_SVH
`define SISO_STATE_SPACE_EVALUATOR_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and command codes for the state-space evaluator.
// No dependencies.
package sse_pkg;

	localparam int STATE_MAX = 4;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int LANES     = 4;  // state fields carried by one transaction
	localparam int USED      = (STATE_MAX < LANES) ? STATE_MAX : LANES;
	localparam int SLOT_B    = STATE_MAX * STATE_MAX;
	localparam int SLOT_C    = SLOT_B + STATE_MAX;
	localparam int SLOT_D    = SLOT_C + STATE_MAX;
	localparam int SLOTS     = SLOT_D + 1;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int IDX_W     = 5;
	localparam int CNT_W     = 3;
	localparam int TERMS     = LANES + 1;  // state terms plus the input term
	localparam int NLANE     = LANES + 1;  // row lanes plus the output lane
	localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
	localparam int SUM_W     = PROD_W + 3;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t term_vec_t [TERMS];

	typedef struct packed {
		logic             adv;
		logic [TERMS-1:0] term_en;
	} lane_ctl_t;

	typedef struct packed {
		word_t sum;
		logic  sat;
	} lane_res_t;

endpackage

// ===== hw/rtl/sse_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for evaluator input and result transactions.
// Depends on sse_pkg.
interface sse_in_if;
	import sse_pkg::*;
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [IDX_W-1:0]    coef_index;
	word_t               coef_value;
	word_t               state_0;
	word_t               state_1;
	word_t               state_2;
	word_t               state_3;
	word_t               drive_in;

	modport source (output valid, cmd, coef_index, coef_value, state_0, state_1, state_2,
		state_3, drive_in, input ready);
	modport sink (input valid, cmd, coef_index, coef_value, state_0, state_1, state_2,
		state_3, drive_in, output ready);
endinterface

interface sse_out_if;
	import sse_pkg::*;
	logic  valid;
	logic  ready;
	word_t next_0;
	word_t next_1;
	word_t next_2;
	word_t next_3;
	word_t model_out;
	logic  saturated;

	modport source (output valid, next_0, next_1, next_2, next_3, model_out, saturated,
		input ready);
	modport sink (input valid, next_0, next_1, next_2, next_3, model_out, saturated,
		output ready);
endinterface

// ===== hw/rtl/siso_state_space_evaluator_core.sv =====
`timescale 1ns / 1ps
// SISO state-space evaluator, signed Q16.16. A load transaction (cmd 0) writes one
// coefficient slot (A row-major 0-15, B 16-19, C 20-23, D 24; higher slots dropped)
// and gives no result. An evaluate transaction (cmd 1) returns next = A*x + B*u per
// row and model_out = C*x + D*u; rows at or beyond state_count read zero, a
// state_count above 4 counts as 4 and zero leaves model_out = D*u. Products drop
// fraction bits (round toward minus infinity), each sum saturates once to 32 bits
// and any saturation sets the saturated flag. Every slot used must be loaded first.
// Throughput is one transaction per cycle while no held result stalls the input: four
// row lanes and an output lane each hold five 32x32 multipliers, and an evaluate goes
// through registered products, pair sums, final sum and saturation, then the output
// register. Loads finish in the cycle they are accepted; an evaluate uses the
// coefficients present when it is accepted. in_ch.ready falls only while a held result is not taken.
// Depends on sse_pkg, sse_if, sse_coef_store, sse_lane, sse_merge and the defines.
`include "siso_state_space_evaluator_core_defines.svh"

module siso_state_space_evaluator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sse_pkg::CNT_W-1:0]  cfg_wdata,
	sse_in_if.sink                     in_ch,
	sse_out_if.source                  out_ch
);
	import sse_pkg::*;

	logic              adv;        // whole pipeline moves one step
	logic              load_we;
	logic [CNT_W-1:0]  state_count_q;
	logic [CNT_W-1:0]  n_eff;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	word_t             coef [SLOTS];
	term_vec_t         opnd;
	term_vec_t         lane_coef [NLANE];
	lane_ctl_t         lane_ctl [NLANE];
	lane_res_t         lane_res [NLANE];

	// pipeline advances whenever the output register is empty or being drained
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;
	assign load_we     = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_LOAD);

	// model order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= CNT_RESET;
		end else if (cfg_we) begin
			state_count_q <= cfg_wdata;
		end
	end

	assign n_eff = (32'(state_count_q) > 32'(USED)) ? CNT_W'(USED) : state_count_q;

	// evaluate valid bits; only evaluates enter the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_ch.valid && (in_ch.cmd == CMD_EVAL);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	sse_coef_store u_store (
		.clk   (clk),
		.we    (load_we),
		.idx   (in_ch.coef_index),
		.wdata (in_ch.coef_value),
		.coef  (coef)
	);

	// shared operand vector: x then u
	assign opnd[0]     = in_ch.state_0;
	assign opnd[1]     = in_ch.state_1;
	assign opnd[2]     = in_ch.state_2;
	assign opnd[3]     = in_ch.state_3;
	assign opnd[LANES] = in_ch.drive_in;

	// coefficient routing: lanes 0..3 take A rows plus B, the last lane takes C plus D
	for (genvar r = 0; r < LANES; r++) begin : g_row
		for (genvar c = 0; c < LANES; c++) begin : g_col
			if (r < STATE_MAX && c < STATE_MAX) begin : g_a
				assign lane_coef[r][c] = coef[r * STATE_MAX + c];
			end else begin : g_a_none
				assign lane_coef[r][c] = '0;
			end
		end
		if (r < STATE_MAX) begin : g_b
			assign lane_coef[r][LANES] = coef[SLOT_B + r];
		end else begin : g_b_none
			assign lane_coef[r][LANES] = '0;
		end
	end

	for (genvar c = 0; c < LANES; c++) begin : g_out_col
		if (c < STATE_MAX) begin : g_c
			assign lane_coef[LANES][c] = coef[SLOT_C + c];
		end else begin : g_c_none
			assign lane_coef[LANES][c] = '0;
		end
	end
	assign lane_coef[LANES][LANES] = coef[SLOT_D];

	// term enables: unused rows drop every term, unused columns drop their term
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			lane_ctl[l].adv = adv;
			for (int c = 0; c < LANES; c++) begin
				lane_ctl[l].term_en[c] = (l == LANES || l < 32'(n_eff)) && (c < 32'(n_eff));
			end
			lane_ctl[l].term_en[LANES] = (l == LANES) || (l < 32'(n_eff));
		end
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		sse_lane u_lane (
			.clk  (clk),
			.ctl  (lane_ctl[l]),
			.coef (lane_coef[l]),
			.opnd (opnd),
			.res  (lane_res[l])
		);
	end

	sse_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s3 (valid_s3),
		.res      (lane_res),
		.out_ch   (out_ch)
	);

	`SSE_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !out_ch.valid, in_ch.ready, "input stalled with empty output register")
	`SSE_ASSERT_NEXT(a_eval_enters, clk, arst_n, in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_EVAL), valid_s1, "accepted evaluate did not enter the lanes")
	`SSE_ASSERT_NEXT(a_load_no_stage, clk, arst_n, adv && !(in_ch.valid && (in_ch.cmd == CMD_EVAL)), !valid_s1, "stage 1 valid without an evaluate")
	`SSE_ASSERT_NEXT(a_result_reaches_out, clk, arst_n, adv && valid_s3, out_ch.valid, "finished result lost before the output register")
	`SSE_ASSERT_NEXT(a_taken_no_refill, clk, arst_n, out_ch.valid && out_ch.ready && !valid_s3, !out_ch.valid, "result repeated after it was taken")

endmodule

// ===== hw/rtl/sse_coef_store.sv =====
`timescale 1ns / 1ps
// Coefficient register file: A row-major, then B, C and D; one write per cycle.
// Depends on sse_pkg.
module sse_coef_store (
	input  logic               clk,
	input  logic               we,
	input  logic [sse_pkg::IDX_W-1:0] idx,
	input  sse_pkg::word_t     wdata,
	output sse_pkg::word_t     coef [sse_pkg::SLOTS]
);
	import sse_pkg::*;

	word_t coef_q [SLOTS];

	// slots past D are dropped
	always_ff @(posedge clk) begin
		if (we && (32'(idx) < 32'(SLOTS))) begin
			coef_q[SLOT_W'(idx)] <= wdata;
		end
	end

	assign coef = coef_q;

endmodule

// ===== hw/rtl/sse_lane.sv =====
`timescale 1ns / 1ps
// One dot-product lane: parallel Q-format products, two-level add, saturation.
// Depends on sse_pkg.
module sse_lane (
	input  logic               clk,
	input  sse_pkg::lane_ctl_t ctl,
	input  sse_pkg::term_vec_t coef,
	input  sse_pkg::term_vec_t opnd,
	output sse_pkg::lane_res_t res
);
	import sse_pkg::*;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  acc_t;

	localparam word_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic signed [2*DATA_W-1:0] full [TERMS];
	prod_t     prod_s1 [TERMS];
	acc_t      pa_s2;
	acc_t      pb_s2;
	acc_t      pc_s2;
	acc_t      tot;
	logic      ovf;
	lane_res_t res_s3;

	always_comb begin
		for (int i = 0; i < TERMS; i++) begin
			full[i] = coef[i] * opnd[i];
		end
	end

	// arithmetic shift drops fraction bits: rounds toward minus infinity
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int i = 0; i < TERMS; i++) begin
				prod_s1[i] <= ctl.term_en[i] ? PROD_W'(full[i] >>> FRAC_BITS) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			pa_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]);
			pb_s2 <= SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]);
			pc_s2 <= SUM_W'(prod_s1[4]);
		end
	end

	assign tot = pa_s2 + pb_s2 + pc_s2;
	// out of range when the bits above the 32-bit sign are not all copies of it
	assign ovf = ~(&tot[SUM_W-1:DATA_W-1]) & (|tot[SUM_W-1:DATA_W-1]);

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			res_s3.sum <= ovf ? (tot[SUM_W-1] ? SAT_MIN : SAT_MAX) : tot[DATA_W-1:0];
			res_s3.sat <= ovf;
		end
	end

	assign res = res_s3;

endmodule

// ===== hw/rtl/sse_merge.sv =====
`timescale 1ns / 1ps
// Output stage: gathers the lane results into one result transaction and holds it.
// Depends on sse_pkg and sse_out_if.
module sse_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_s3,
	input  sse_pkg::lane_res_t res [sse_pkg::NLANE],
	sse_out_if.source          out_ch
);
	import sse_pkg::*;

	logic  out_valid_q;
	word_t next_q [LANES];
	word_t model_q;
	logic  sat_q;
	logic  any_sat;

	always_comb begin
		any_sat = 1'b0;
		for (int i = 0; i < NLANE; i++) begin
			any_sat = any_sat | res[i].sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			for (int i = 0; i < LANES; i++) begin
				next_q[i] <= res[i].sum;
			end
			model_q <= res[LANES].sum;
			sat_q   <= any_sat;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.next_0    = next_q[0];
	assign out_ch.next_1    = next_q[1];
	assign out_ch.next_2    = next_q[2];
	assign out_ch.next_3    = next_q[3];
	assign out_ch.model_out = model_q;
	assign out_ch.saturated = sat_q;

endmodule
